### hw/rtl/assert_macros.svh
// Assertion macros shared by the speedometer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/pso_pkg.sv
// Shared types and constants for the wheel-pulse speedometer/odometer.
// No dependencies; used by every module of the block.
package pso_pkg;

   // Shared adder width and distance product width
   localparam int ACC_W = 48;
   localparam int DIST_W = 42;
   localparam int CNT_W = 6;

   // Configuration port geometry
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Speed limit and sequencer step counts (last index of each loop)
   localparam logic [7:0] SPEED_MAX = 8'd199;
   localparam logic [CNT_W-1:0] CIRC_LAST = 6'd11;
   localparam logic [CNT_W-1:0] COMP_LAST = 6'd9;
   localparam logic [CNT_W-1:0] DIV_LAST = 6'd41;
   localparam logic [CNT_W-1:0] SPD_LAST = 6'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CIRC    = 3'd0,
      CSR_COMP    = 3'd1,
      CSR_PPT     = 3'd2,
      CSR_TIMEOUT = 3'd3,
      CSR_WINDOW  = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [11:0] circ;
      logic [9:0]  comp;
      logic [7:0]  ppt;
      logic [15:0] timeout_ms;
      logic [15:0] window_ms;
   } cfg_type;

   // Window snapshot handed from the timebase to the sequencer
   typedef struct packed {
      logic        update;
      logic        timeout;
      logic [15:0] pulses;
      logic [15:0] wtime;
   } win_type;

   // Result handed from the sequencer to the output register
   typedef struct packed {
      logic [7:0]  speed;
      logic [31:0] distance;
      logic        updated;
      logic        timed_out;
   } res_type;

   // Operation for the shared adder/subtractor
   typedef struct packed {
      logic [ACC_W-1:0] a;
      logic [ACC_W-1:0] b;
      logic             sub;
   } alu_op_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_MUL_CIRC,
      SEQ_MUL_COMP,
      SEQ_MUL_TEN,
      SEQ_DIV_PPT,
      SEQ_ODO,
      SEQ_SCALE,
      SEQ_DIV_SPD,
      SEQ_FINAL,
      SEQ_DONE
   } seq_state_type;

endpackage

### hw/rtl/pso_alu.sv
// Shared wide adder/subtractor used for every multiply, divide and add step.
// Depends on pso_pkg.
module pso_alu (
   input  pso_pkg::alu_op_type             op,
   output logic [pso_pkg::ACC_W-1:0]       result,
   output logic                            carry
);

   logic [pso_pkg::ACC_W-1:0] b_eff;
   logic [pso_pkg::ACC_W:0]   full;

   // a + b, or a - b with carry set when a >= b
   always_comb begin
      b_eff = op.sub ? ~op.b : op.b;
      full = {1'b0, op.a} + {1'b0, b_eff} + {{pso_pkg::ACC_W{1'b0}}, op.sub};
      result = full[pso_pkg::ACC_W-1:0];
      carry = full[pso_pkg::ACC_W];
   end

endmodule

### hw/rtl/pso_timebase.sv
// Millisecond divider, timeout flag, edge detector and window counters.
// Depends on pso_pkg; advances one tick per accepted transaction.
module pso_timebase #(
   parameter int TICKS_PER_MS = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              pin_level,
   input  pso_pkg::cfg_type  cfg,
   output pso_pkg::win_type  win
);

   logic [4:0]  tick_div_ff, tick_div_in;
   logic [15:0] ms_ff, ms_in;
   logic        prev_ff;
   logic [15:0] wtime_ff, wtime_in;
   logic [15:0] pulses_ff, pulses_in;
   logic        flag_ff, flag_in;

   logic [4:0]  td_inc;
   logic [16:0] ms_sum, wt_sum, pl_sum;
   logic [15:0] ms_tick, wt_edge, pl_edge;
   logic        flag_tick, rise, upd;

   assign td_inc = tick_div_ff + 5'd1;
   assign ms_sum = {1'b0, ms_ff} + 17'd1;
   assign rise = pin_level & ~prev_ff;

   // Millisecond/timeout step, then edge, then update decision
   always_comb begin
      tick_div_in = td_inc;
      ms_tick = ms_ff;
      flag_tick = flag_ff;
      if (td_inc >= 5'(TICKS_PER_MS)) begin
         tick_div_in = '0;
         ms_tick = ms_sum[16] ? 16'hFFFF : ms_sum[15:0];
         if ((ms_tick >= cfg.timeout_ms) && !flag_ff) begin
            ms_tick = '0;
            flag_tick = 1'b1;
         end
      end

      wt_sum = {1'b0, wtime_ff} + {1'b0, ms_tick};
      pl_sum = {1'b0, pulses_ff} + 17'd1;
      ms_in = ms_tick;
      wt_edge = wtime_ff;
      pl_edge = pulses_ff;
      if (rise) begin
         pl_edge = pl_sum[16] ? 16'hFFFF : pl_sum[15:0];
         wt_edge = wt_sum[16] ? 16'hFFFF : wt_sum[15:0];
         ms_in = '0;
      end

      upd = (wt_edge >= cfg.window_ms) || flag_tick;
      win.update = upd;
      win.timeout = flag_tick;
      win.pulses = pl_edge;
      win.wtime = wt_edge;

      // an update consumes the window and the pending timeout
      pulses_in = upd ? 16'd0 : pl_edge;
      wtime_in = upd ? 16'd0 : wt_edge;
      flag_in = upd ? 1'b0 : flag_tick;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_div_ff <= '0;
         ms_ff <= '0;
         prev_ff <= 1'b0;
         wtime_ff <= '0;
         pulses_ff <= '0;
         flag_ff <= 1'b0;
      end else if (step) begin
         tick_div_ff <= tick_div_in;
         ms_ff <= ms_in;
         prev_ff <= pin_level;
         wtime_ff <= wtime_in;
         pulses_ff <= pulses_in;
         flag_ff <= flag_in;
      end
   end

endmodule

### hw/rtl/pso_seq.sv
// Update sequencer: distance and speed through repeated use of one adder.
// Depends on pso_pkg and pso_alu; holds the odometer and the held speed.
module pso_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pso_pkg::win_type  win,
   input  pso_pkg::cfg_type  cfg,
   input  logic              out_free,
   output logic              idle,
   output logic              done,
   output pso_pkg::res_type  res
);

   localparam int AW = pso_pkg::ACC_W;
   localparam int DW = pso_pkg::DIST_W;
   localparam logic [pso_pkg::CNT_W-1:0] CNT_ONE = 1;

   pso_pkg::seq_state_type state_ff, state_in;

   logic [AW-1:0]               acc_ff, acc_in;
   logic [AW-1:0]               mcand_ff, mcand_in;
   logic [11:0]                 mplr_ff, mplr_in;
   logic [pso_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [8:0]                  q_ff, q_in;
   logic [15:0]                 wtime_ff, wtime_in;
   logic                        pnz_ff, pnz_in;
   logic                        tmo_ff, tmo_in;
   logic                        upd_ff, upd_in;
   logic [7:0]                  speed_ff, speed_in;
   logic [31:0]                 odo_ff, odo_in;

   pso_pkg::alu_op_type op;
   logic [AW-1:0] alu_res;
   logic          alu_carry;

   logic [7:0]    ppt_eff;
   logic [18:0]   den;
   logic [DW-1:0] dist_mm;
   logic [AW-1:0] div_rem;
   logic [1:0]    bonus;
   logic [8:0]    spd_sum;
   logic [7:0]    spd_fin;

   pso_alu u_alu (
      .op     (op),
      .result (alu_res),
      .carry  (alu_carry)
   );

   assign ppt_eff = (cfg.ppt == 8'd0) ? 8'd1 : cfg.ppt;
   assign den = {1'b0, wtime_ff, 2'b00} + {3'b000, wtime_ff};
   assign dist_mm = mcand_ff[DW-1:0];
   assign div_rem = {acc_ff[AW-2:0], mcand_ff[DW-1]};

   // speed * 102 / 100 = q + q / 50, saturated to the display limit
   always_comb begin
      if (q_ff[7:0] >= 8'd150) begin
         bonus = 2'd3;
      end else if (q_ff[7:0] >= 8'd100) begin
         bonus = 2'd2;
      end else if (q_ff[7:0] >= 8'd50) begin
         bonus = 2'd1;
      end else begin
         bonus = 2'd0;
      end
      spd_sum = {1'b0, q_ff[7:0]} + {7'd0, bonus};
      if (q_ff[8] || (spd_sum > {1'b0, pso_pkg::SPEED_MAX})) begin
         spd_fin = pso_pkg::SPEED_MAX;
      end else begin
         spd_fin = spd_sum[7:0];
      end
   end

   // Next state and datapath control
   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplr_in = mplr_ff;
      cnt_in = cnt_ff;
      q_in = q_ff;
      wtime_in = wtime_ff;
      pnz_in = pnz_ff;
      tmo_in = tmo_ff;
      upd_in = upd_ff;
      speed_in = speed_ff;
      odo_in = odo_ff;
      op.a = acc_ff;
      op.b = mcand_ff;
      op.sub = 1'b0;

      case (state_ff)
         pso_pkg::SEQ_IDLE: begin
            if (start) begin
               if (win.update) begin
                  acc_in = '0;
                  mcand_in = AW'(win.pulses);
                  mplr_in = cfg.circ;
                  cnt_in = pso_pkg::CIRC_LAST;
                  wtime_in = win.wtime;
                  pnz_in = |win.pulses;
                  tmo_in = win.timeout;
                  upd_in = 1'b1;
                  state_in = pso_pkg::SEQ_MUL_CIRC;
               end else begin
                  tmo_in = 1'b0;
                  upd_in = 1'b0;
                  state_in = pso_pkg::SEQ_DONE;
               end
            end
         end
         // shift-add multiply, multiplier bits MSB first
         pso_pkg::SEQ_MUL_CIRC, pso_pkg::SEQ_MUL_COMP: begin
            op.a = {acc_ff[AW-2:0], 1'b0};
            op.b = mplr_ff[11] ? mcand_ff : '0;
            acc_in = alu_res;
            mplr_in = {mplr_ff[10:0], 1'b0};
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_ff == '0) begin
               if (state_ff == pso_pkg::SEQ_MUL_CIRC) begin
                  mcand_in = alu_res;
                  acc_in = '0;
                  mplr_in = {cfg.comp, 2'b00};
                  cnt_in = pso_pkg::COMP_LAST;
                  state_in = pso_pkg::SEQ_MUL_COMP;
               end else begin
                  state_in = pso_pkg::SEQ_MUL_TEN;
               end
            end
         end
         // times ten as x*8 + x*2
         pso_pkg::SEQ_MUL_TEN: begin
            op.a = {acc_ff[AW-4:0], 3'b000};
            op.b = {acc_ff[AW-2:0], 1'b0};
            mcand_in = alu_res;
            acc_in = '0;
            cnt_in = pso_pkg::DIV_LAST;
            state_in = pso_pkg::SEQ_DIV_PPT;
         end
         // restoring division by pulses per turn, one quotient bit per cycle
         pso_pkg::SEQ_DIV_PPT: begin
            op.a = div_rem;
            op.b = AW'(ppt_eff);
            op.sub = 1'b1;
            acc_in = alu_carry ? alu_res : div_rem;
            mcand_in = {mcand_ff[AW-2:0], alu_carry};
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_ff == '0) begin
               state_in = pso_pkg::SEQ_ODO;
            end
         end
         // odometer add; pick the speed path
         pso_pkg::SEQ_ODO: begin
            op.a = AW'(odo_ff);
            op.b = AW'(dist_mm[31:0]);
            odo_in = alu_res[31:0];
            if (tmo_ff) begin
               speed_in = pnz_ff ? 8'd1 : 8'd0;
               state_in = pso_pkg::SEQ_DONE;
            end else if (wtime_ff == 16'd0) begin
               speed_in = (dist_mm != '0) ? pso_pkg::SPEED_MAX : 8'd0;
               state_in = pso_pkg::SEQ_DONE;
            end else begin
               state_in = pso_pkg::SEQ_SCALE;
            end
         end
         // distance * 18, divisor 5 * window time aligned for nine quotient bits
         pso_pkg::SEQ_SCALE: begin
            op.a = AW'({dist_mm, 4'b0000});
            op.b = AW'({dist_mm, 1'b0});
            acc_in = alu_res;
            mcand_in = AW'({den, 8'h00});
            q_in = '0;
            cnt_in = pso_pkg::SPD_LAST;
            state_in = pso_pkg::SEQ_DIV_SPD;
         end
         pso_pkg::SEQ_DIV_SPD: begin
            op.a = acc_ff;
            op.b = mcand_ff;
            op.sub = 1'b1;
            if (alu_carry) begin
               acc_in = alu_res;
            end
            q_in = {q_ff[7:0], alu_carry};
            mcand_in = {1'b0, mcand_ff[AW-1:1]};
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_ff == '0) begin
               state_in = pso_pkg::SEQ_FINAL;
            end
         end
         pso_pkg::SEQ_FINAL: begin
            speed_in = spd_fin;
            state_in = pso_pkg::SEQ_DONE;
         end
         pso_pkg::SEQ_DONE: begin
            if (out_free) begin
               state_in = pso_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = pso_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pso_pkg::SEQ_IDLE;
         speed_ff <= '0;
         odo_ff <= '0;
      end else begin
         state_ff <= state_in;
         speed_ff <= speed_in;
         odo_ff <= odo_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff <= mplr_in;
      cnt_ff <= cnt_in;
      q_ff <= q_in;
      wtime_ff <= wtime_in;
      pnz_ff <= pnz_in;
      tmo_ff <= tmo_in;
      upd_ff <= upd_in;
   end

   assign idle = (state_ff == pso_pkg::SEQ_IDLE);
   assign done = (state_ff == pso_pkg::SEQ_DONE) && out_free;
   assign res.speed = speed_ff;
   assign res.distance = odo_ff;
   assign res.updated = upd_ff;
   assign res.timed_out = tmo_ff;

endmodule

### hw/rtl/pulse_speedometer_odometer.sv
// Wheel-pulse speedometer and odometer, top level.
// Usage:
//   req_* carries one 50 us tick with the sampled sensor pin (req_pin_level).
//   rsp_* returns one result per tick: held speed in km/h, odometer in mm,
//   an update flag and a timeout flag.
//   csr_* writes the five settings (circumference, compensation, pulses per
//   turn, timeout, window); write only while no tick is outstanding.
// Sequencing (acceptance to result handshake):
//   A tick without a speed update goes straight to the done state.
//   A tick that updates runs the shared 48-bit adder through 12 + 10 + 1
//   multiply steps, 42 divide steps, the odometer add and, for a measured
//   speed, 1 + 9 + 1 more steps, then the done state. One tick is in flight
//   at a time; req_ready is high only while the sequencer is idle.
// Reset: settings return to 200 cm, 1, 1, 2000 ms, 500 ms; counters, the
//   odometer and the held speed clear to zero.
// Stall: a result waits in the output register until rsp_ready; the
//   sequencer holds its finished transaction and takes no new tick meanwhile.
`include "assert_macros.svh"

module pulse_speedometer_odometer #(
   parameter int TICKS_PER_MS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_pin_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_speed_kmh,
   output logic [31:0] rsp_distance_total,
   output logic        rsp_speed_updated,
   output logic        rsp_timed_out,
   input  logic        csr_write_en,
   input  logic [pso_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pso_pkg::CSR_DATA_W-1:0] csr_wdata
);

   pso_pkg::cfg_type cfg_ff, cfg_in;
   pso_pkg::win_type win;
   pso_pkg::res_type res;

   logic accept, seq_idle, seq_done, out_free;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0]  speed_ff;
   logic [31:0] dist_ff;
   logic        upd_ff;
   logic        tmo_ff;
   logic        speed_ok, tmo_shown, tmo_ok;

   assign accept = req_valid && req_ready;
   assign req_ready = seq_idle;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (pso_pkg::csr_idx_type'(csr_index))
            pso_pkg::CSR_CIRC:    cfg_in.circ = csr_wdata[11:0];
            pso_pkg::CSR_COMP:    cfg_in.comp = csr_wdata[9:0];
            pso_pkg::CSR_PPT:     cfg_in.ppt = csr_wdata[7:0];
            pso_pkg::CSR_TIMEOUT: cfg_in.timeout_ms = csr_wdata;
            pso_pkg::CSR_WINDOW:  cfg_in.window_ms = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.circ <= 12'd200;
         cfg_ff.comp <= 10'd1;
         cfg_ff.ppt <= 8'd1;
         cfg_ff.timeout_ms <= 16'd2000;
         cfg_ff.window_ms <= 16'd500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pso_timebase #(
      .TICKS_PER_MS (TICKS_PER_MS)
   ) u_timebase (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .pin_level (req_pin_level),
      .cfg       (cfg_ff),
      .win       (win)
   );

   pso_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .win      (win),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .idle     (seq_idle),
      .done     (seq_done),
      .res      (res)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) begin
         speed_ff <= res.speed;
         dist_ff <= res.distance;
         upd_ff <= res.updated;
         tmo_ff <= res.timed_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_speed_kmh = speed_ff;
   assign rsp_distance_total = dist_ff;
   assign rsp_speed_updated = upd_ff;
   assign rsp_timed_out = tmo_ff;

   // Checks
   assign speed_ok = (rsp_speed_kmh <= pso_pkg::SPEED_MAX);
   assign tmo_shown = rsp_valid && rsp_timed_out;
   assign tmo_ok = rsp_speed_updated && (rsp_speed_kmh <= 8'd1);

   `PSO_ASSERT_NOW(a_speed_limit, clock, reset, rsp_valid, speed_ok, "speed above limit")
   `PSO_ASSERT_NOW(a_timeout_speed, clock, reset, tmo_shown, tmo_ok, "bad timeout result")
   `PSO_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ready, "tick taken while busy")

endmodule

### sim/pso_checker.sv
// Checker for the wheel-pulse speedometer: mirrors the settings and the tick
// arithmetic, then compares every returned reading with the predicted one.
// Depends on pso_pkg; instantiated by tb_top beside the block.
module pso_checker #(
   parameter int TICKS_PER_MS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_pin_level,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_speed_kmh,
   input  logic [31:0] rsp_distance_total,
   input  logic        rsp_speed_updated,
   input  logic        rsp_timed_out,
   input  logic        csr_write_en,
   input  logic [pso_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pso_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   localparam logic [15:0] CNT_MAX = 16'hFFFF;
   localparam int REPORT_LIMIT = 10;

   // Settings after reset
   localparam logic [11:0] CIRC_RESET = 12'd200;
   localparam logic [9:0]  COMP_RESET = 10'd1;
   localparam logic [7:0]  PPT_RESET = 8'd1;
   localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [15:0] WINDOW_RESET = 16'd500;

   // Mirrored settings
   logic [11:0] circ_cm;
   logic [9:0]  comp_mult;
   logic [7:0]  ppt_div;
   logic [15:0] timeout_lim;
   logic [15:0] window_lim;

   // Mirrored tick state
   logic [4:0]  tick_count;
   logic [15:0] ms_idle;
   logic        last_pin;
   logic [15:0] win_ms;
   logic [15:0] win_pulses;
   logic        timeout_pending;
   logic [31:0] odo_mm;
   logic [7:0]  speed_hold;

   pso_pkg::res_type expected_readings[$];
   int      mismatches = 0;

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[16] ? CNT_MAX : sum[15:0];
   endfunction

   // One 50 us tick: ms/timeout step, edge detection, then the update check
   function automatic pso_pkg::res_type advance_tick(input logic pin);
      pso_pkg::res_type reading;
      logic [63:0] dist_mm;
      logic [63:0] spd;
      logic [63:0] divisor;
      logic        updated;
      logic        by_timeout;
      updated = 1'b0;
      by_timeout = 1'b0;

      tick_count = tick_count + 5'd1;
      if (tick_count >= TICKS_PER_MS) begin
         tick_count = '0;
         ms_idle = sat_add(ms_idle, 16'd1);
         if (ms_idle >= timeout_lim && !timeout_pending) begin
            ms_idle = '0;
            timeout_pending = 1'b1;
         end
      end

      if (pin && !last_pin) begin
         win_pulses = sat_add(win_pulses, 16'd1);
         win_ms = sat_add(win_ms, ms_idle);
         ms_idle = '0;
      end
      last_pin = pin;

      if (win_ms >= window_lim || timeout_pending) begin
         // pulses per turn of zero divides by one
         divisor = (ppt_div == '0) ? 64'd1 : 64'(ppt_div);
         dist_mm = 64'(win_pulses) * 64'(circ_cm) * 64'd10 * 64'(comp_mult) / divisor;
         if (timeout_pending) begin
            spd = (win_pulses != '0) ? 64'd1 : 64'd0;
            by_timeout = 1'b1;
         end else if (win_ms == '0) begin
            spd = (dist_mm != '0) ? 64'(pso_pkg::SPEED_MAX) : 64'd0;
         end else begin
            // mm per ms to km/h
            spd = dist_mm * 64'd36 / 64'd10 / 64'(win_ms);
         end
         odo_mm = odo_mm + dist_mm[31:0];
         win_pulses = '0;
         win_ms = '0;
         timeout_pending = 1'b0;
         if (spd != '0)
            spd = spd * 64'd102 / 64'd100;
         if (spd > 64'(pso_pkg::SPEED_MAX))
            spd = 64'(pso_pkg::SPEED_MAX);
         speed_hold = spd[7:0];
         updated = 1'b1;
      end

      reading.speed = speed_hold;
      reading.distance = odo_mm;
      reading.updated = updated;
      reading.timed_out = by_timeout;
      return reading;
   endfunction

   // Watch the three ports; readings are checked before new ticks are queued
   always @(posedge clock) begin
      pso_pkg::res_type want;
      if (reset) begin
         circ_cm = CIRC_RESET;
         comp_mult = COMP_RESET;
         ppt_div = PPT_RESET;
         timeout_lim = TIMEOUT_RESET;
         window_lim = WINDOW_RESET;
         tick_count = '0;
         ms_idle = '0;
         last_pin = 1'b0;
         win_ms = '0;
         win_pulses = '0;
         timeout_pending = 1'b0;
         odo_mm = '0;
         speed_hold = '0;
         expected_readings.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("reading with no tick outstanding: speed %0d dist %0d upd %0b to %0b",
                           rsp_speed_kmh, rsp_distance_total, rsp_speed_updated,
                           rsp_timed_out);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_speed_kmh !== want.speed || rsp_distance_total !== want.distance ||
                   rsp_speed_updated !== want.updated || rsp_timed_out !== want.timed_out) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("reading mismatch: expected speed %0d dist %0d upd %0b to %0b",
                              want.speed, want.distance, want.updated, want.timed_out);
                     $display("                  actual   speed %0d dist %0d upd %0b to %0b",
                              rsp_speed_kmh, rsp_distance_total, rsp_speed_updated,
                              rsp_timed_out);
                  end
               end
            end
         end

         if (csr_write_en) begin
            case (csr_index)
               pso_pkg::CSR_CIRC:    circ_cm = csr_wdata[11:0];
               pso_pkg::CSR_COMP:    comp_mult = csr_wdata[9:0];
               pso_pkg::CSR_PPT:     ppt_div = csr_wdata[7:0];
               pso_pkg::CSR_TIMEOUT: timeout_lim = csr_wdata;
               pso_pkg::CSR_WINDOW:  window_lim = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && req_ready)
            expected_readings.push_back(advance_tick(req_pin_level));
      end
      fail_count <= mismatches;
      pending <= expected_readings.size();
   end

endmodule

### sim/tb_top.sv
// Testbench top for the wheel-pulse speedometer: drives ticks and settings,
// stalls the reading port, and reports the verdict from pso_checker.
// Depends on pso_pkg, pulse_speedometer_odometer and pso_checker.
module tb_top;

   localparam int TICKS_PER_MS = 20;
   localparam int LIMIT_CYCLES = 500_000;
   localparam int DRAIN_CYCLES = 100;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES = 9;
   localparam int TICKS_PER_PHASE = 60;
   localparam int HOLD_PHASE = 2;
   localparam int IDX_W = pso_pkg::CSR_IDX_W;
   localparam int DATA_W = pso_pkg::CSR_DATA_W;
   localparam logic [IDX_W-1:0] CSR_SPARE_FIRST = pso_pkg::CSR_WINDOW + 3'd1;
   localparam logic [IDX_W-1:0] CSR_SPARE_LAST = '1;
   localparam int DIRECTED_LEN = 22;
   localparam logic [DIRECTED_LEN-1:0] DIRECTED_PINS = 22'b10_1010_1011_1001_1100_0010;

   // Idle and stall percentages per traffic mode
   localparam int SEND_IDLE[4] = '{0, 49, 0, 36};
   localparam int RECV_STALL[4] = '{0, 0, 49, 36};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_pin_level;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_speed_kmh;
   logic [31:0] rsp_distance_total;
   logic        rsp_speed_updated;
   logic        rsp_timed_out;
   logic        csr_write_en;
   logic [IDX_W-1:0]  csr_index;
   logic [DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked = 0;
   int cycle_count = 0;

   pulse_speedometer_odometer #(
      .TICKS_PER_MS(TICKS_PER_MS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pin_level(req_pin_level),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_speed_kmh(rsp_speed_kmh),
      .rsp_distance_total(rsp_distance_total),
      .rsp_speed_updated(rsp_speed_updated),
      .rsp_timed_out(rsp_timed_out),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   pso_checker #(
      .TICKS_PER_MS(TICKS_PER_MS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pin_level(req_pin_level),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_speed_kmh(rsp_speed_kmh),
      .rsp_distance_total(rsp_distance_total),
      .rsp_speed_updated(rsp_speed_updated),
      .rsp_timed_out(rsp_timed_out),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Reading port: random stalls, plus a long hold-off on request
   initial begin
      int hold_served;
      hold_served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            hold_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Offer one tick, called at a falling edge; returns at the falling edge
   // after the transaction, leaving valid high for the next tick
   task automatic send_tick(input logic pin);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pin_level <= pin;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop offering and wait for every outstanding reading
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all five settings, random bits above the three narrower fields, then a spare index
   task automatic program_settings(input logic [11:0] circ, input logic [9:0] comp,
                                   input logic [7:0] ppt, input logic [15:0] tmo,
                                   input logic [15:0] win);
      csr_write_en <= 1'b1;
      csr_index <= pso_pkg::CSR_CIRC;
      csr_wdata <= {4'($urandom), circ};
      @(negedge clock);
      csr_index <= pso_pkg::CSR_COMP;
      csr_wdata <= {6'($urandom), comp};
      @(negedge clock);
      csr_index <= pso_pkg::CSR_PPT;
      csr_wdata <= {8'($urandom), ppt};
      @(negedge clock);
      csr_index <= pso_pkg::CSR_TIMEOUT;
      csr_wdata <= tmo;
      @(negedge clock);
      csr_index <= pso_pkg::CSR_WINDOW;
      csr_wdata <= win;
      @(negedge clock);
      csr_index <= IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST));
      csr_wdata <= DATA_W'($urandom);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int   run_left;
      logic level;
      logic pin;
      run_left = 0;
      level = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pin_level = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: two ticks on reset settings, then widest distance, zero
      // divisor, zero window and a 1 ms timeout so both triggers coincide
      send_tick(1'b1);
      send_tick(1'b0);
      wait_drained();
      program_settings(12'd4095, 10'd1023, 8'd0, 16'd1, 16'd0);
      for (int i = DIRECTED_LEN - 1; i >= 0; i--)
         send_tick(DIRECTED_PINS[i]);
      wait_drained();

      // Random phases: pin runs across millisecond boundaries, some glitches
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_settings(12'd4095, 10'd1023, 8'd255, 16'hFFFF, 16'hFFFF);
            1: program_settings(12'd0, 10'd0, 8'd0, 16'd0, 16'd0);
            2: program_settings(12'd4095, 10'd1023, 8'd1, 16'd3, 16'd1);
            default: begin
               if (p % 2 == 1)
                  program_settings(12'($urandom_range(1, 40)), 10'($urandom_range(1, 4)),
                                   8'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                                   16'($urandom_range(0, 4)));
               else
                  program_settings(12'($urandom), 10'($urandom), 8'($urandom),
                                   16'($urandom_range(1, 6)), 16'($urandom_range(0, 4)));
            end
         endcase
         send_idle_pct = SEND_IDLE[p % 4];
         recv_stall_pct = RECV_STALL[p % 4];
         for (int i = 0; i < TICKS_PER_PHASE; i++) begin
            if (p == HOLD_PHASE && i == 10)
               hold_asked++;
            if (run_left == 0) begin
               level = !level;
               run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
                                                       : $urandom_range(3, 30);
            end
            run_left--;
            pin = ($urandom_range(0, 15) == 0) ? 1'($urandom) : level;
            send_tick(pin);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/pso_pkg.sv
hw/rtl/pso_alu.sv
hw/rtl/pso_timebase.sv
hw/rtl/pso_seq.sv
hw/rtl/pulse_speedometer_odometer.sv
sim/pso_checker.sv
sim/tb_top.sv
